@@ src/nta_pkg.sv @@
// ----------------------------------------------------------------------------
// nta_pkg: shared types and constants of the neighbor table
// Request and status codes, entry layout, field widths and reset values.
// ----------------------------------------------------------------------------
package nta_pkg;

  localparam int unsigned TABLE_DEPTH_DEF  = 512;
  localparam int unsigned IP_W             = 32;
  localparam int unsigned PORT_W           = 16;
  localparam int unsigned AGE_W            = 16;
  localparam int unsigned IDX_W            = 9;
  localparam int unsigned CNT_W            = 10;
  localparam int unsigned APB_AW           = 3;
  localparam int unsigned APB_DW           = 32;
  localparam logic [AGE_W-1:0] AGE_RELOAD_RST = 16'd120;

  // word index of the reload register on the config port
  localparam logic REG_AGE_RELOAD = 1'b0;

  typedef enum logic [1:0] {
    REQ_LEARN  = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    STS_INSERTED  = 3'd0,
    STS_REFRESHED = 3'd1,
    STS_DELETED   = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_FULL      = 3'd4,
    STS_TICK_DONE = 3'd5,
    STS_CLEARED   = 3'd6
  } status_e;

  typedef struct packed {
    logic              valid;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
    logic [AGE_W-1:0]  age;
  } entry_t;

endpackage

@@ src/nta_regs.sv @@
// ----------------------------------------------------------------------------
// nta_regs: configuration registers
// APB-style port holding the age reload value.
// ----------------------------------------------------------------------------
module nta_regs
  import nta_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [AGE_W-1:0]  age_reload_o
);

  logic [AGE_W-1:0] age_reload_q;
  logic             wr_en;

  assign pready       = 1'b1;
  assign wr_en        = psel && penable && pwrite && pready;
  assign age_reload_o = age_reload_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_reload_q <= AGE_RELOAD_RST;
    end else if (wr_en && (paddr[2] == REG_AGE_RELOAD)) begin
      age_reload_q <= pwdata[AGE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_AGE_RELOAD) begin
      prdata = APB_DW'(age_reload_q);
    end
  end

endmodule

@@ src/nta_mem.sv @@
// ----------------------------------------------------------------------------
// nta_mem: entry memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module nta_mem
  import nta_pkg::*;
#(
  parameter int unsigned DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/nta_ctrl.sv @@
// ----------------------------------------------------------------------------
// nta_ctrl: request sequencer
// Sweeps the entry memory for search, aging and clearing, and holds the
// result register.
// ----------------------------------------------------------------------------
module nta_ctrl
  import nta_pkg::*;
#(
  parameter int unsigned DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        req_type_i,
  input  logic [IP_W-1:0]   peer_ip_i,
  input  logic [PORT_W-1:0] peer_port_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        status_o,
  output logic [IDX_W-1:0]  entry_index_o,
  output logic [CNT_W-1:0]  live_count_o,
  output logic [CNT_W-1:0]  expired_count_o,
  input  logic [AGE_W-1:0]  age_reload_i,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output entry_t            mem_wdata_o,
  output logic              mem_re_o,
  output logic [AW-1:0]     mem_raddr_o,
  input  entry_t            mem_rdata_i
);

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_SCAN,
    ST_TICK,
    ST_WR,
    ST_DONE
  } state_e;

  state_e            st_q;
  logic              boot_q;
  logic [AW-1:0]     addr_q;
  logic              iss_q;
  logic              rd_v_q;
  logic [AW-1:0]     rd_idx_q;
  req_type_e         req_q;
  logic [IP_W-1:0]   ip_q;
  logic [PORT_W-1:0] port_q;
  logic              hit_q;
  logic [AW-1:0]     hit_idx_q;
  logic              free_q;
  logic [AW-1:0]     free_idx_q;
  logic [CW-1:0]     live_q;
  logic [CW-1:0]     exp_q;
  status_e           res_sts_q;
  logic [AW-1:0]     res_idx_q;
  logic              out_valid_q;
  status_e           out_sts_q;
  logic [AW-1:0]     out_idx_q;
  logic [CW-1:0]     out_live_q;
  logic [CW-1:0]     out_exp_q;

  logic              match_now;
  logic              hit_d;
  logic [AW-1:0]     hit_idx_d;
  logic              free_d;
  logic [AW-1:0]     free_idx_d;
  logic              expire_now;
  logic [CW-1:0]     exp_d;
  logic              last_data;

  assign in_ready_o = (st_q == ST_IDLE);

  // compare the returning entry against the request key
  assign match_now  = rd_v_q && mem_rdata_i.valid &&
                      (mem_rdata_i.ip == ip_q) && (mem_rdata_i.port == port_q);
  assign hit_d      = hit_q || match_now;
  assign hit_idx_d  = hit_q ? hit_idx_q : rd_idx_q;
  assign free_d     = free_q || (rd_v_q && !mem_rdata_i.valid);
  assign free_idx_d = free_q ? free_idx_q : rd_idx_q;
  // only a tick sweep retires entries
  assign expire_now = (st_q == ST_TICK) && rd_v_q && mem_rdata_i.valid &&
                      (mem_rdata_i.age <= AGE_W'(1));
  assign exp_d      = exp_q + CW'(expire_now);
  assign last_data  = rd_v_q && (rd_idx_q == LAST);

  assign mem_re_o    = ((st_q == ST_SCAN) || (st_q == ST_TICK)) && iss_q;
  assign mem_raddr_o = addr_q;

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = addr_q;
    mem_wdata_o = '0;
    unique case (st_q)
      ST_CLR: begin
        mem_we_o = 1'b1;
      end
      ST_TICK: begin
        mem_waddr_o = rd_idx_q;
        if (rd_v_q && mem_rdata_i.valid) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = mem_rdata_i;
          if (expire_now) begin
            mem_wdata_o.valid = 1'b0;
          end else begin
            mem_wdata_o.age = mem_rdata_i.age - AGE_W'(1);
          end
        end
      end
      ST_WR: begin
        mem_we_o          = 1'b1;
        mem_waddr_o       = res_idx_q;
        mem_wdata_o.valid = (req_q == REQ_LEARN);
        mem_wdata_o.ip    = ip_q;
        mem_wdata_o.port  = port_q;
        mem_wdata_o.age   = age_reload_i;
      end
      default: begin
        mem_we_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLR;
      boot_q      <= 1'b1;
      addr_q      <= '0;
      iss_q       <= 1'b0;
      rd_v_q      <= 1'b0;
      rd_idx_q    <= '0;
      req_q       <= REQ_LEARN;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      free_q      <= 1'b0;
      free_idx_q  <= '0;
      live_q      <= '0;
      exp_q       <= '0;
      res_sts_q   <= STS_INSERTED;
      res_idx_q   <= '0;
      out_valid_q <= 1'b0;
      out_sts_q   <= STS_INSERTED;
      out_idx_q   <= '0;
      out_live_q  <= '0;
      out_exp_q   <= '0;
    end else begin
      rd_v_q   <= mem_re_o;
      rd_idx_q <= addr_q;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        ST_CLR: begin
          addr_q <= addr_q + AW'(1);
          if (addr_q == LAST) begin
            addr_q <= '0;
            if (boot_q) begin
              boot_q <= 1'b0;
              st_q   <= ST_IDLE;
            end else begin
              res_sts_q <= STS_CLEARED;
              res_idx_q <= '0;
              st_q      <= ST_DONE;
            end
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            req_q  <= req_type_e'(req_type_i);
            ip_q   <= peer_ip_i;
            port_q <= peer_port_i;
            hit_q  <= 1'b0;
            free_q <= 1'b0;
            exp_q  <= '0;
            addr_q <= '0;
            unique case (req_type_e'(req_type_i))
              REQ_CLEAR: begin
                live_q <= '0;
                st_q   <= ST_CLR;
              end
              REQ_TICK: begin
                iss_q <= 1'b1;
                st_q  <= ST_TICK;
              end
              default: begin
                iss_q <= 1'b1;
                st_q  <= ST_SCAN;
              end
            endcase
          end
        end
        ST_SCAN, ST_TICK: begin
          // issue one read per cycle until the last slot
          if (iss_q) begin
            addr_q <= addr_q + AW'(1);
            if (addr_q == LAST) begin
              iss_q  <= 1'b0;
              addr_q <= '0;
            end
          end
          hit_q      <= hit_d;
          hit_idx_q  <= hit_idx_d;
          free_q     <= free_d;
          free_idx_q <= free_idx_d;
          exp_q      <= exp_d;
          if (last_data) begin
            if (st_q == ST_TICK) begin
              live_q    <= live_q - exp_d;
              res_sts_q <= STS_TICK_DONE;
              res_idx_q <= '0;
              st_q      <= ST_DONE;
            end else if (hit_d) begin
              res_sts_q <= (req_q == REQ_LEARN) ? STS_REFRESHED : STS_DELETED;
              res_idx_q <= hit_idx_d;
              if (req_q != REQ_LEARN) begin
                live_q <= live_q - CW'(1);
              end
              st_q <= ST_WR;
            end else if ((req_q == REQ_LEARN) && free_d) begin
              res_sts_q <= STS_INSERTED;
              res_idx_q <= free_idx_d;
              live_q    <= live_q + CW'(1);
              st_q      <= ST_WR;
            end else begin
              res_sts_q <= (req_q == REQ_LEARN) ? STS_FULL : STS_NOT_FOUND;
              res_idx_q <= '0;
              st_q      <= ST_DONE;
            end
          end
        end
        ST_WR: begin
          st_q <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the result register frees up
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_sts_q   <= res_sts_q;
            out_idx_q   <= res_idx_q;
            out_live_q  <= live_q;
            out_exp_q   <= exp_q;
            st_q        <= ST_IDLE;
          end
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_sts_q;
  assign entry_index_o   = IDX_W'(out_idx_q);
  assign live_count_o    = CNT_W'(out_live_q);
  assign expired_count_o = CNT_W'(out_exp_q);

  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CW'(DEPTH))
    else $error("live count exceeds table depth");

  a_rd_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_v_q |-> ((st_q == ST_SCAN) || (st_q == ST_TICK)))
    else $error("read data returned outside a sweep");

  a_clr_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CLR) |-> (live_q == '0))
    else $error("live count nonzero during clear pass");

  a_no_wr_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> !mem_we_o)
    else $error("memory write while accepting a request");

endmodule

@@ src/neighbor_table_with_aging_top.sv @@
// A learn or delete sweeps all slots, and one that writes an entry then passes the write
//   state before its result is registered; a tick sweeps all slots and a clear writes them.
// Throughput: one request at a time; the next is taken once the result is registered,
//   which waits while a previous result still sits in the output register.
// Reset: valid count and control clear at once, then a clearing pass
//   invalidates every slot while no request is taken; config writes work throughout.
// ----------------------------------------------------------------------------
// neighbor_table_with_aging_top: peer table with aging
// Learn, delete, age tick and clear requests over a memory of peer entries.
// ----------------------------------------------------------------------------
module neighbor_table_with_aging_top
  import nta_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        req_type_i,
  input  logic [IP_W-1:0]   peer_ip_i,
  input  logic [PORT_W-1:0] peer_port_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        status_o,
  output logic [IDX_W-1:0]  entry_index_o,
  output logic [CNT_W-1:0]  live_count_o,
  output logic [CNT_W-1:0]  expired_count_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic [AGE_W-1:0] age_reload;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  entry_t           mem_rdata;

  nta_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .age_reload_o (age_reload)
  );

  nta_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  nta_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .peer_ip_i       (peer_ip_i),
    .peer_port_i     (peer_port_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .entry_index_o   (entry_index_o),
    .live_count_o    (live_count_o),
    .expired_count_o (expired_count_o),
    .age_reload_i    (age_reload),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata)
  );

endmodule

@@ verif/tb_neighbor_table_with_aging_top.sv @@
// ----------------------------------------------------------------------------
// tb_neighbor_table_with_aging_top: self-checking bench for the peer table
// Runs a directed table of learn, delete, tick and clear requests, then
// random traffic over small key pools and a full-table fill. Every result is
// checked against the directed table's expected reply or an in-bench model of
// the table, and the reload register is read back after each write.
// ----------------------------------------------------------------------------
module tb_neighbor_table_with_aging_top
  import nta_pkg::*;
();

  localparam int unsigned DEPTH          = TABLE_DEPTH_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES    = 600;
  localparam int unsigned HOLD_CYCLES    = 3000;
  localparam int unsigned POOL_MAX       = 32;
  localparam logic [APB_AW-1:0] RELOAD_ADDR = APB_AW'(REG_AGE_RELOAD) << 2;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] index;
    logic [CNT_W-1:0] live;
    logic [CNT_W-1:0] expired;
  } table_result_t;

  typedef struct packed {
    row_kind_e         kind;
    req_type_e         rt;
    logic [IP_W-1:0]   ip;     // reload value on config rows
    logic [PORT_W-1:0] port;
    logic              typed;
    table_result_t     want;
  } stim_row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [1:0]        req_type_i  = REQ_LEARN;
  logic [IP_W-1:0]   peer_ip_i   = '0;
  logic [PORT_W-1:0] peer_port_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [2:0]        status_o;
  logic [IDX_W-1:0]  entry_index_o;
  logic [CNT_W-1:0]  live_count_o;
  logic [CNT_W-1:0]  expired_count_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [APB_AW-1:0] paddr       = '0;
  logic [APB_DW-1:0] pwdata      = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // model of the table
  logic              tbl_valid [DEPTH];
  logic [IP_W-1:0]   tbl_ip    [DEPTH];
  logic [PORT_W-1:0] tbl_port  [DEPTH];
  logic [AGE_W-1:0]  tbl_age   [DEPTH];
  int unsigned       tbl_live;
  logic [AGE_W-1:0]  cur_reload;

  table_result_t     reply_q [$];
  int unsigned       err_cnt      = 0;
  int unsigned       results_seen = 0;
  int unsigned       idle_cycles  = 0;
  bit                gaps_on      = 1'b1;
  bit                held_off     = 1'b0;
  logic [IP_W-1:0]   pool_ip   [POOL_MAX];
  logic [PORT_W-1:0] pool_port [POOL_MAX];
  logic [IP_W-1:0]   fill_ip   [DEPTH];

  stim_row_t dir_rows [0:23] = '{
    '{ROW_REQ, REQ_TICK,   32'h0,        16'h0,    1'b1, '{STS_TICK_DONE, 9'd0, 10'd0, 10'd0}},
    '{ROW_REQ, REQ_DELETE, 32'h0,        16'h0,    1'b1, '{STS_NOT_FOUND, 9'd0, 10'd0, 10'd0}},
    '{ROW_REQ, REQ_LEARN,  32'h0,        16'h0,    1'b1, '{STS_INSERTED,  9'd0, 10'd1, 10'd0}},
    '{ROW_REQ, REQ_LEARN,  32'hFFFFFFFF, 16'hFFFF, 1'b1, '{STS_INSERTED,  9'd1, 10'd2, 10'd0}},
    '{ROW_REQ, REQ_LEARN,  32'h0,        16'h0,    1'b1, '{STS_REFRESHED, 9'd0, 10'd2, 10'd0}},
    '{ROW_REQ, REQ_LEARN,  32'h0,        16'hFFFF, 1'b1, '{STS_INSERTED,  9'd2, 10'd3, 10'd0}},
    '{ROW_REQ, REQ_LEARN,  32'hFFFFFFFF, 16'h0,    1'b1, '{STS_INSERTED,  9'd3, 10'd4, 10'd0}},
    '{ROW_REQ, REQ_DELETE, 32'hFFFFFFFF, 16'hFFFF, 1'b1, '{STS_DELETED,   9'd1, 10'd3, 10'd0}},
    '{ROW_REQ, REQ_DELETE, 32'hFFFFFFFF, 16'hFFFF, 1'b1, '{STS_NOT_FOUND, 9'd0, 10'd3, 10'd0}},
    '{ROW_REQ, REQ_LEARN,  32'hA5A5A5A5, 16'h5A5A, 1'b1, '{STS_INSERTED,  9'd1, 10'd4, 10'd0}},
    '{ROW_REQ, REQ_TICK,   32'h5A5A5A5A, 16'hA5A5, 1'b1, '{STS_TICK_DONE, 9'd0, 10'd4, 10'd0}},
    '{ROW_REQ, REQ_CLEAR,  32'hFFFFFFFF, 16'hFFFF, 1'b1, '{STS_CLEARED,   9'd0, 10'd0, 10'd0}},
    '{ROW_REQ, REQ_LEARN,  32'h12345678, 16'h1234, 1'b1, '{STS_INSERTED,  9'd0, 10'd1, 10'd0}},
    // zero reload: entries die at the next tick
    '{ROW_CFG, REQ_LEARN,  32'd0,        16'h0,    1'b0, '0},
    '{ROW_REQ, REQ_LEARN,  32'h12345678, 16'h1234, 1'b1, '{STS_REFRESHED, 9'd0, 10'd1, 10'd0}},
    '{ROW_REQ, REQ_LEARN,  32'h80000001, 16'h8001, 1'b1, '{STS_INSERTED,  9'd1, 10'd2, 10'd0}},
    '{ROW_CFG, REQ_LEARN,  32'd2,        16'h0,    1'b0, '0},
    '{ROW_REQ, REQ_LEARN,  32'h7FFFFFFE, 16'h7FFE, 1'b1, '{STS_INSERTED,  9'd2, 10'd3, 10'd0}},
    '{ROW_REQ, REQ_TICK,   32'h0,        16'h0,    1'b1, '{STS_TICK_DONE, 9'd0, 10'd1, 10'd2}},
    '{ROW_REQ, REQ_LEARN,  32'h12345678, 16'h5678, 1'b0, '0},
    '{ROW_REQ, REQ_TICK,   32'hFFFFFFFF, 16'h0,    1'b0, '0},
    '{ROW_REQ, REQ_DELETE, 32'h7FFFFFFE, 16'h7FFE, 1'b1, '{STS_NOT_FOUND, 9'd0, 10'd1, 10'd0}},
    '{ROW_CFG, REQ_LEARN,  32'd65535,    16'h0,    1'b0, '0},
    '{ROW_REQ, REQ_LEARN,  32'h12345678, 16'h5678, 1'b0, '0}
  };

  neighbor_table_with_aging_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .peer_ip_i      (peer_ip_i),
    .peer_port_i    (peer_port_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .entry_index_o  (entry_index_o),
    .live_count_o   (live_count_o),
    .expired_count_o(expired_count_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  // apply one request to the table model and return its reply
  function automatic table_result_t peer_table_update(input req_type_e rt,
                                                      input logic [IP_W-1:0] ip,
                                                      input logic [PORT_W-1:0] port);
    table_result_t r;
    int hit;
    int free_slot;
    int s;
    int unsigned gone;
    hit = -1;
    free_slot = -1;
    gone = 0;
    r = '0;
    for (s = 0; s < DEPTH; s++) begin
      if (hit < 0 && tbl_valid[s] && tbl_ip[s] == ip && tbl_port[s] == port) hit = s;
      if (free_slot < 0 && !tbl_valid[s]) free_slot = s;
    end
    case (rt)
      REQ_LEARN: begin
        if (hit >= 0) begin
          tbl_age[hit] = cur_reload;
          r.status = STS_REFRESHED;
          r.index = IDX_W'(hit);
        end else if (free_slot >= 0) begin
          tbl_valid[free_slot] = 1'b1;
          tbl_ip[free_slot] = ip;
          tbl_port[free_slot] = port;
          tbl_age[free_slot] = cur_reload;
          tbl_live++;
          r.status = STS_INSERTED;
          r.index = IDX_W'(free_slot);
        end else begin
          r.status = STS_FULL;
        end
      end
      REQ_DELETE: begin
        if (hit >= 0) begin
          tbl_valid[hit] = 1'b0;
          tbl_live--;
          r.status = STS_DELETED;
          r.index = IDX_W'(hit);
        end else begin
          r.status = STS_NOT_FOUND;
        end
      end
      REQ_TICK: begin
        for (s = 0; s < DEPTH; s++) begin
          if (tbl_valid[s]) begin
            if (tbl_age[s] <= 1) begin
              tbl_valid[s] = 1'b0;
              gone++;
            end else begin
              tbl_age[s] = tbl_age[s] - AGE_W'(1);
            end
          end
        end
        tbl_live = tbl_live - gone;
        r.status = STS_TICK_DONE;
      end
      default: begin
        for (s = 0; s < DEPTH; s++) tbl_valid[s] = 1'b0;
        tbl_live = 0;
        r.status = STS_CLEARED;
      end
    endcase
    r.live = CNT_W'(tbl_live);
    r.expired = CNT_W'(gone);
    return r;
  endfunction

  // offer one request and hold it until taken; valid stays high on return
  task automatic send_req(input req_type_e rt, input logic [IP_W-1:0] ip,
                          input logic [PORT_W-1:0] port, input bit typed,
                          input table_result_t want);
    int unsigned gap;
    table_result_t got;
    gap = gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= rt;
    peer_ip_i   <= ip;
    peer_port_i <= port;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    got = peer_table_update(rt, ip, port);
    reply_q.insert(reply_q.size(), typed ? want : got);
  endtask

  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reload(input logic [AGE_W-1:0] value);
    logic [APB_DW-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RELOAD_ADDR;
    pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cur_reload = value;
    // read back in the next transfer
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    check_field("age_reload", APB_DW'(value), rd);
  endtask

  task automatic run_random(input int unsigned count, input int unsigned pool_size);
    int unsigned k;
    int unsigned r;
    int unsigned p;
    req_type_e rt;
    logic [IP_W-1:0] ip;
    logic [PORT_W-1:0] port;
    // pairs of keys share the address or the port so both key halves matter
    for (k = 0; k < pool_size; k++) begin
      pool_ip[k]   = (k % 2 == 1) ? pool_ip[k-1] : $urandom;
      pool_port[k] = (k % 4 == 2) ? pool_port[k-2] : PORT_W'($urandom);
    end
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 50) rt = REQ_LEARN;
      else if (r < 75) rt = REQ_DELETE;
      else if (r < 97) rt = REQ_TICK;
      else rt = REQ_CLEAR;
      if ($urandom_range(0, 9) == 0) begin
        ip = $urandom;
        port = PORT_W'($urandom);
      end else begin
        p = $urandom_range(0, pool_size - 1);
        ip = pool_ip[p];
        port = pool_port[p];
      end
      send_req(rt, ip, port, 1'b0, '0);
    end
  endtask

  // request side
  initial begin
    int unsigned i;
    int unsigned k;
    for (i = 0; i < DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_ip[i] = '0;
      tbl_port[i] = '0;
      tbl_age[i] = '0;
    end
    tbl_live = 0;
    cur_reload = AGE_RELOAD_RST;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_requests();
        write_reload(dir_rows[i].ip[AGE_W-1:0]);
      end else begin
        send_req(dir_rows[i].rt, dir_rows[i].ip, dir_rows[i].port,
                 dir_rows[i].typed, dir_rows[i].want);
      end
    end

    drain_requests();
    write_reload(16'd5);
    run_random(300, 24);

    // fill every slot back to back, then probe the full table
    drain_requests();
    write_reload(16'd1);
    gaps_on = 1'b0;
    send_req(REQ_CLEAR, $urandom, PORT_W'($urandom), 1'b0, '0);
    for (i = 0; i < DEPTH; i++) begin
      fill_ip[i] = $urandom;
      send_req(REQ_LEARN, fill_ip[i], PORT_W'(i), 1'b0, '0);
    end
    gaps_on = 1'b1;
    for (i = 0; i < 3; i++) send_req(REQ_LEARN, $urandom, PORT_W'(1024 + i), 1'b0, '0);
    for (i = 0; i < 3; i++) begin
      k = $urandom_range(0, DEPTH - 1);
      send_req(REQ_LEARN, fill_ip[k], PORT_W'(k), 1'b0, '0);
    end
    k = $urandom_range(0, DEPTH - 1);
    send_req(REQ_DELETE, fill_ip[k], PORT_W'(k), 1'b0, '0);
    send_req(REQ_LEARN, $urandom, 16'd2000, 1'b0, '0);
    send_req(REQ_LEARN, $urandom, 16'd2001, 1'b0, '0);
    send_req(REQ_TICK, $urandom, PORT_W'($urandom), 1'b0, '0);
    send_req(REQ_TICK, $urandom, PORT_W'($urandom), 1'b0, '0);

    drain_requests();
    write_reload(16'd65535);
    run_random(150, 16);
    drain_requests();
    write_reload(16'd3);
    run_random(150, 32);

    drain_requests();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("neighbor_table_with_aging_top: match");
    end else begin
      $display("neighbor_table_with_aging_top: mismatch");
    end
    $finish;
  end

  // result side: random back-pressure, one long hold-off early in the run
  initial begin
    int unsigned gap;
    forever begin
      gap = pick_gap();
      if (!held_off && results_seen >= 40) begin
        gap = HOLD_CYCLES;
        held_off = 1'b1;
      end
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 600) : $urandom_range(1, 6))
        @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    table_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (reply_q.size() == 0) begin
        $error("unexpected result: status %0d, entry_index %0d", status_o, entry_index_o);
        err_cnt++;
      end else begin
        want = reply_q.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("entry_index", 32'(want.index), 32'(entry_index_o));
        check_field("live_count", 32'(want.live), 32'(live_count_o));
        check_field("expired_count", 32'(want.expired), 32'(expired_count_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("neighbor_table_with_aging_top: mismatch");
      $finish;
    end
  end

endmodule
